[src/bfsp_pkg.sv]
// bfsp_pkg: shared constants, command codes and sequencer states for the
// shortest-path unit; no dependencies
package bfsp_pkg;

  localparam int DEF_MAX_NODES = 64;
  localparam int DEF_COST_BITS = 16;

  // fixed field widths of the channels and the config port
  localparam int CMD_W      = 2;
  localparam int NODE_IN_W  = 6;
  localparam int VALUE_W    = 16;
  localparam int PRED_W     = 7;
  localparam int NCOUNT_W   = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [PRED_W-1:0]    PRED_NONE     = '1;
  localparam logic [NCOUNT_W-1:0]  NCOUNT_RESET  = NCOUNT_W'(1);
  localparam logic [VALUE_W-1:0]   INF_RESET     = VALUE_W'(16);

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INFINITY   = CFG_IDX_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_INIT,
    ST_ROW,
    ST_PAIR_RD,
    ST_PAIR_CMP,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

endpackage

[src/bfsp_if.sv]
// bfsp_in_if / bfsp_out_if: valid-ready channels for command words and
// result words; depends on bfsp_pkg
interface bfsp_in_if;
  import bfsp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [NODE_IN_W-1:0] from_node;
  logic [NODE_IN_W-1:0] to_node;
  logic [VALUE_W-1:0]   edge_value;

  modport source (output valid, command, from_node, to_node, edge_value, input ready);
  modport sink   (input valid, command, from_node, to_node, edge_value, output ready);
endinterface

interface bfsp_out_if;
  import bfsp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [NODE_IN_W-1:0]     node_index;
  logic [VALUE_W-1:0]       distance;
  logic signed [PRED_W-1:0] predecessor;
  logic                     last;

  modport source (output valid, node_index, distance, predecessor, last, input ready);
  modport sink   (input valid, node_index, distance, predecessor, last, output ready);
endinterface

[src/bfsp_ram.sv]
// bfsp_ram: generic simple dual-port ram, one write and one registered read
// no package dependency
module bfsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/bellman_ford_shortest_paths_unit.sv]
// bellman_ford_shortest_paths_unit: single-source shortest paths over a stored
// cost matrix; depends on bfsp_pkg, bfsp_if (channels) and bfsp_ram
//
//   channel  dir  word                                        handshake
//   in_word  in   command, from_node, to_node, edge_value     valid/ready
//   out_word out  node_index, distance, predecessor, last     valid/ready
//   cfg_*    in   cfg_index, cfg_wdata                        cfg_we, no wait
//
// edge write: ready again next cycle
// clear: writes every matrix entry, one matrix entry a cycle, not ready meanwhile
// run (n nodes): an init step per node, then n-1 rounds of n rows; each row
//   fetches the row distance, then reads and compares each node pair in turn in
//   the one shared add/compare unit; then each result is read and emitted
// reset: synchronous active-low rst_n clears control and sets config to its
//   defaults; the matrix is undefined until cleared or written, distances until a run
// stalls: a result waits in the output register; the emit walk pauses while it is held
module bellman_ford_shortest_paths_unit #(
  parameter int MAX_NODES = bfsp_pkg::DEF_MAX_NODES,
  parameter int COST_BITS = bfsp_pkg::DEF_COST_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bfsp_in_if.sink                         in_word,
  bfsp_out_if.source                      out_word,
  input  logic                            cfg_we,
  input  logic [bfsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfsp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bfsp_pkg::*;

  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int EDGE_DEPTH = MAX_NODES * MAX_NODES;
  localparam int EA_W       = $clog2(EDGE_DEPTH);
  localparam logic [31:0]     COST_MASK  = (COST_BITS >= 32) ? 32'hFFFF_FFFF
                                           : ((32'd1 << COST_BITS) - 32'd1);
  localparam logic [EA_W-1:0] ROW_STRIDE = EA_W'(MAX_NODES);
  localparam logic [EA_W-1:0] EA_LAST    = EA_W'(EDGE_DEPTH - 1);

  // config registers
  logic [NCOUNT_W-1:0] nodes_cfg_r;
  logic [VALUE_W-1:0]  infinity_cost_r;

  // sequencer state
  state_t              state_r, state_nxt;
  logic [NODE_W-1:0]   i_r, i_nxt;          // row / init / emit node
  logic [NODE_W-1:0]   j_r, j_nxt;          // column node
  logic [NODE_W-1:0]   k_r, k_nxt;          // round number
  logic [NODE_W-1:0]   last_idx_r, last_idx_nxt;
  logic [EA_W-1:0]     row_base_r, row_base_nxt;
  logic [EA_W-1:0]     clr_r, clr_nxt;
  logic [COST_BITS-1:0] d_i_r, d_i_nxt;     // distance of the current row node

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic [NODE_IN_W-1:0]     out_node_r, out_node_nxt;
  logic [VALUE_W-1:0]       out_dist_r, out_dist_nxt;
  logic [PRED_W-1:0]        out_pred_r, out_pred_nxt;
  logic                     out_last_r, out_last_nxt;

  // ram ports
  logic                 edge_we;
  logic [EA_W-1:0]      edge_waddr, edge_raddr;
  logic [COST_BITS-1:0] edge_wdata, edge_rdata;
  logic                 dist_we;
  logic [NODE_W-1:0]    dist_waddr, dist_raddr;
  logic [COST_BITS-1:0] dist_wdata, dist_rdata;
  logic [PRED_W-1:0]    pred_wdata, pred_rdata;

  // derived values
  logic [31:0]          inf_wide, val_wide, nc_wide;
  logic [COST_BITS-1:0] eff_inf, clamped;
  logic                 in_fire, in_range, slot_free;
  logic [COST_BITS:0]   sum;
  logic                 better;
  logic [EA_W-1:0]      wr_addr;

  assign in_fire   = in_word.valid && in_word.ready;
  assign slot_free = !out_valid_r || out_word.ready;

  // infinity limited to the cost width; edge values clamped to it
  assign inf_wide = {16'b0, infinity_cost_r};
  assign eff_inf  = (inf_wide > COST_MASK) ? COST_MASK[COST_BITS-1:0]
                                           : inf_wide[COST_BITS-1:0];
  assign val_wide = {16'b0, in_word.edge_value};
  assign clamped  = (val_wide > 32'(eff_inf)) ? eff_inf : val_wide[COST_BITS-1:0];

  assign in_range = (32'(in_word.from_node) < MAX_NODES) &&
                    (32'(in_word.to_node) < MAX_NODES);
  assign wr_addr  = EA_W'(32'(in_word.from_node) * MAX_NODES + 32'(in_word.to_node));
  assign nc_wide  = 32'(nodes_cfg_r);

  // the shared add/compare unit: strict less-than, one extra bit so no wrap
  assign sum    = {1'b0, d_i_r} + {1'b0, edge_rdata};
  assign better = {1'b0, dist_rdata} > sum;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    last_idx_nxt  = last_idx_r;
    row_base_nxt  = row_base_r;
    clr_nxt       = clr_r;
    d_i_nxt       = d_i_r;
    out_valid_nxt = out_valid_r && !out_word.ready;
    out_node_nxt  = out_node_r;
    out_dist_nxt  = out_dist_r;
    out_pred_nxt  = out_pred_r;
    out_last_nxt  = out_last_r;
    edge_we       = 1'b0;
    edge_waddr    = wr_addr;
    edge_wdata    = clamped;
    edge_raddr    = row_base_r + EA_W'(j_r);
    dist_we       = 1'b0;
    dist_waddr    = i_r;
    dist_wdata    = eff_inf;
    pred_wdata    = PRED_NONE;
    dist_raddr    = (state_r == ST_PAIR_RD) ? j_r : i_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_word.command)
            CMD_WRITE: edge_we = in_range;
            CMD_CLEAR: begin
              clr_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            CMD_RUN: begin
              if (nodes_cfg_r == '0) begin
                last_idx_nxt = '0;
              end else if (nc_wide > MAX_NODES) begin
                last_idx_nxt = NODE_W'(MAX_NODES - 1);
              end else begin
                last_idx_nxt = NODE_W'(nc_wide - 32'd1);
              end
              i_nxt     = '0;
              state_nxt = ST_INIT;
            end
            default: ;  // unused code, dropped
          endcase
        end
      end

      ST_CLEAR: begin
        edge_we    = 1'b1;
        edge_waddr = clr_r;
        edge_wdata = eff_inf;
        clr_nxt    = clr_r + EA_W'(1);
        if (clr_r == EA_LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      // source gets 0, others infinity, no predecessor
      ST_INIT: begin
        dist_we    = 1'b1;
        dist_wdata = (i_r == '0) ? '0 : eff_inf;
        if (i_r == last_idx_r) begin
          i_nxt = '0;
          if (last_idx_r == '0) begin
            state_nxt = ST_EMIT_RD;
          end else begin
            j_nxt        = '0;
            k_nxt        = NODE_W'(1);
            row_base_nxt = '0;
            state_nxt    = ST_ROW;
          end
        end else begin
          i_nxt = i_r + NODE_W'(1);
        end
      end

      // fetch distance of row node i
      ST_ROW: state_nxt = ST_PAIR_RD;

      // fetch dist[j] and edge[i][j]; row distance arrives on the first pair
      ST_PAIR_RD: begin
        if (j_r == '0) begin
          d_i_nxt = dist_rdata;
        end
        state_nxt = ST_PAIR_CMP;
      end

      ST_PAIR_CMP: begin
        if (better) begin
          dist_we    = 1'b1;
          dist_waddr = j_r;
          dist_wdata = sum[COST_BITS-1:0];
          pred_wdata = PRED_W'(i_r);
        end
        if (j_r == last_idx_r) begin
          j_nxt = '0;
          if (i_r == last_idx_r) begin
            i_nxt        = '0;
            row_base_nxt = '0;
            if (k_r == last_idx_r) begin
              state_nxt = ST_EMIT_RD;
            end else begin
              k_nxt     = k_r + NODE_W'(1);
              state_nxt = ST_ROW;
            end
          end else begin
            i_nxt        = i_r + NODE_W'(1);
            row_base_nxt = row_base_r + ROW_STRIDE;
            state_nxt    = ST_ROW;
          end
        end else begin
          j_nxt     = j_r + NODE_W'(1);
          state_nxt = ST_PAIR_RD;
        end
      end

      ST_EMIT_RD: state_nxt = ST_EMIT_OUT;

      // read address held on i, so the data stays while the output stalls
      ST_EMIT_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = NODE_IN_W'(i_r);
          out_dist_nxt  = VALUE_W'(dist_rdata);
          out_pred_nxt  = pred_rdata;
          out_last_nxt  = (i_r == last_idx_r);
          if (i_r == last_idx_r) begin
            state_nxt = ST_IDLE;
          end else begin
            i_nxt     = i_r + NODE_W'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      out_valid_r     <= 1'b0;
      nodes_cfg_r     <= NCOUNT_RESET;
      infinity_cost_r <= INF_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NODE_COUNT: nodes_cfg_r     <= cfg_wdata[NCOUNT_W-1:0];
          CFG_INFINITY:   infinity_cost_r <= cfg_wdata[VALUE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // counters and payload, no reset needed
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    last_idx_r <= last_idx_nxt;
    row_base_r <= row_base_nxt;
    clr_r      <= clr_nxt;
    d_i_r      <= d_i_nxt;
    out_node_r <= out_node_nxt;
    out_dist_r <= out_dist_nxt;
    out_pred_r <= out_pred_nxt;
    out_last_r <= out_last_nxt;
  end

  bfsp_ram #(.WIDTH(COST_BITS), .DEPTH(EDGE_DEPTH)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  bfsp_ram #(.WIDTH(COST_BITS), .DEPTH(MAX_NODES)) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (dist_raddr),
    .rdata (dist_rdata)
  );

  // predecessor written together with distance, its read data used only while emitting
  bfsp_ram #(.WIDTH(PRED_W), .DEPTH(MAX_NODES)) u_pred_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (pred_wdata),
    .raddr (i_r),
    .rdata (pred_rdata)
  );

  assign in_word.ready        = (state_r == ST_IDLE);
  assign out_word.valid       = out_valid_r;
  assign out_word.node_index  = out_node_r;
  assign out_word.distance    = out_dist_r;
  assign out_word.predecessor = out_pred_r;
  assign out_word.last        = out_last_r;

endmodule
